// File: hdl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types, codes and the segment table of the tick-driven I2C master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    localparam int SEG_W = 5;

    // command codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS    = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [7:0] PHASE_TICKS_RESET    = 8'd5;
    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd255;

    // segment numbers of the transaction sequence
    localparam logic [SEG_W-1:0] SEG_IDLE     = 5'd0;
    localparam logic [SEG_W-1:0] SEG_WR_START = 5'd1;
    localparam logic [SEG_W-1:0] SEG_WR_DEV   = 5'd2;
    localparam logic [SEG_W-1:0] SEG_WR_REG   = 5'd4;
    localparam logic [SEG_W-1:0] SEG_WR_DATA  = 5'd6;
    localparam logic [SEG_W-1:0] SEG_RD_START = 5'd9;
    localparam logic [SEG_W-1:0] SEG_RD_DEV   = 5'd10;
    localparam logic [SEG_W-1:0] SEG_RD_REG   = 5'd12;
    localparam logic [SEG_W-1:0] SEG_RD_DEVR  = 5'd15;
    localparam logic [SEG_W-1:0] SEG_RD_BYTE  = 5'd17;
    localparam logic [SEG_W-1:0] SEG_RD_ACK   = 5'd18;
    localparam logic [SEG_W-1:0] SEG_RD_STOP  = 5'd19;
    localparam logic [SEG_W-1:0] SEG_LAST     = 5'd19;

    typedef enum logic [2:0] {
        K_IDLE,
        K_START,
        K_WB,
        K_WA,
        K_RB,
        K_ACK,
        K_STOP
    } kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] device_addr;
        logic [7:0] register_addr;
        logic [7:0] wr_data;
        logic [7:0] read_length;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic       ack_missing;
        logic       busy_res;
        logic       done_res;
    } res_t;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] ack_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [SEG_W-1:0] seq_step;
        logic [2:0]       sub_step;
        logic [7:0]       phase_count;
        logic [2:0]       bit_index;
        logic [7:0]       shift_byte;
        logic [7:0]       poll_count;
        logic [7:0]       bytes_left;
        logic             is_read;
        logic [7:0]       held_device_addr;
        logic [7:0]       held_register_addr;
        logic [7:0]       held_wr_data;
        logic             scl_level;
        logic             sda_level;
        logic             sda_dir_out;
    } state_t;

    // scl idles high, everything else clear
    localparam state_t STATE_RESET = '{scl_level: 1'b1, default: '0};

    function automatic kind_t kind_of(input logic [SEG_W-1:0] s);
        kind_t k;
        case (s)
            5'd1, 5'd9, 5'd14:                      k = K_START;
            5'd2, 5'd4, 5'd6, 5'd10, 5'd12, 5'd15:  k = K_WB;
            5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd16:  k = K_WA;
            5'd17:                                  k = K_RB;
            5'd18:                                  k = K_ACK;
            5'd8, 5'd19:                            k = K_STOP;
            default:                                k = K_IDLE;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/i2crm_if.sv
// ----------------------------------------------------------------------------
// i2crm_if
// Valid/ready channels of the I2C master: command ticks, results, config.
// ----------------------------------------------------------------------------
interface i2crm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] device_addr;
    logic [7:0] register_addr;
    logic [7:0] wr_data;
    logic [7:0] read_length;
    logic       sda_in;

    modport source
    (
        output valid, func, device_addr, register_addr, wr_data, read_length, sda_in,
        input  ready
    );
    modport sink
    (
        input  valid, func, device_addr, register_addr, wr_data, read_length, sda_in,
        output ready
    );
endinterface

interface i2crm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       ack_missing;
    logic       busy_res;
    logic       done_res;

    modport source
    (
        output valid, scl_out, sda_out, sda_drive, rd_data, rd_valid, rd_last,
               ack_missing, busy_res, done_res,
        input  ready
    );
    modport sink
    (
        input  valid, scl_out, sda_out, sda_drive, rd_data, rd_valid, rd_last,
               ack_missing, busy_res, done_res,
        output ready
    );
endinterface

interface i2crm_cfg_if;
    logic       valid;
    logic       ready;
    logic       addr;
    logic [7:0] data;

    modport source
    (
        output valid, addr, data,
        input  ready
    );
    modport sink
    (
        input  valid, addr, data,
        output ready
    );
endinterface

// File: hdl/i2crm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2crm_cfg_regs
// Configuration registers: phase length and acknowledge poll limit.
// ----------------------------------------------------------------------------
module i2crm_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    i2crm_cfg_if.sink         cfg,
    output i2crm_pkg::cfg_t   cfg_val
);
    import i2crm_pkg::*;

    logic [7:0] phase_ticks_reg;
    logic [7:0] ack_poll_limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg    <= PHASE_TICKS_RESET;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg.data;
                CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    assign cfg_val.phase_ticks    = phase_ticks_reg;
    assign cfg_val.ack_poll_limit = ack_poll_limit_reg;

endmodule

// File: hdl/i2crm_step.sv
// ----------------------------------------------------------------------------
// i2crm_step
// One bus tick: next sequencer state and the line levels for that tick.
// ----------------------------------------------------------------------------
module i2crm_step
(
    input  i2crm_pkg::state_t st,
    input  i2crm_pkg::cfg_t   cfg_val,
    input  i2crm_pkg::cmd_t   cmd_item,
    output i2crm_pkg::state_t st_next,
    output i2crm_pkg::res_t   res_item
);
    import i2crm_pkg::*;

    function automatic state_t init_segment(input state_t s, input logic [SEG_W-1:0] seg);
        state_t r;
        r = s;
        r.seq_step    = seg;
        r.sub_step    = 3'd0;
        r.bit_index   = 3'd0;
        r.phase_count = 8'd0;
        r.poll_count  = 8'd0;
        case (seg)
            SEG_WR_DEV, SEG_RD_DEV: r.shift_byte = s.held_device_addr;
            SEG_WR_REG, SEG_RD_REG: r.shift_byte = s.held_register_addr;
            SEG_WR_DATA:            r.shift_byte = s.held_wr_data;
            SEG_RD_DEVR:            r.shift_byte = s.held_device_addr | 8'h01;
            default:                r.shift_byte = 8'd0;
        endcase
        return r;
    endfunction

    function automatic state_t advance(input state_t s);
        state_t r;
        if (s.seq_step == SEG_RD_ACK)
            r = init_segment(s, (s.bytes_left != 8'd0) ? SEG_RD_BYTE : SEG_RD_STOP);
        else if (s.seq_step < SEG_LAST)
            r = init_segment(s, s.seq_step + 5'd1);
        else
            r = init_segment(s, SEG_IDLE);
        return r;
    endfunction

    // line changes applied on the first tick of a phase
    function automatic state_t enter_phase(input state_t s);
        state_t r;
        r = s;
        case (kind_of(s.seq_step))
            K_START:
            begin
                if (s.sub_step == 3'd0)
                begin
                    r.sda_dir_out = 1'b1;
                    r.sda_level   = 1'b1;
                end
                else if (s.sub_step == 3'd1)
                    r.scl_level = 1'b1;
                else
                    r.sda_level = 1'b0;
            end
            K_WB:
            begin
                if (s.sub_step == 3'd0)
                begin
                    r.sda_dir_out = 1'b1;
                    r.scl_level   = 1'b0;
                end
                else if (s.sub_step == 3'd1)
                begin
                    r.sda_level  = s.shift_byte[7];
                    r.shift_byte = {s.shift_byte[6:0], 1'b0};
                end
                else if (s.sub_step == 3'd2)
                    r.scl_level = 1'b1;
                else
                    r.scl_level = 1'b0;
            end
            K_WA:
            begin
                if (s.sub_step == 3'd0 || s.sub_step == 3'd4)
                    r.scl_level = 1'b0;
                else if (s.sub_step == 3'd1)
                begin
                    r.sda_level   = 1'b1;
                    r.sda_dir_out = 1'b0;
                end
                else
                    r.scl_level = 1'b1;
            end
            K_RB:
            begin
                if (s.sub_step == 3'd0)
                begin
                    r.sda_dir_out = 1'b0;
                    r.scl_level   = 1'b0;
                end
                else if (s.sub_step == 3'd1)
                    r.scl_level = 1'b1;
                else
                    r.scl_level = 1'b0;
            end
            K_ACK:
            begin
                if (s.sub_step == 3'd0)
                begin
                    r.sda_dir_out = 1'b1;
                    r.scl_level   = 1'b0;
                end
                else if (s.sub_step == 3'd1)
                    r.sda_level = (s.bytes_left > 8'd1) ? 1'b0 : 1'b1;
                else if (s.sub_step == 3'd2)
                    r.scl_level = 1'b1;
                else
                    r.scl_level = 1'b0;
            end
            K_STOP:
            begin
                if (s.sub_step == 3'd0)
                begin
                    r.sda_dir_out = 1'b1;
                    r.scl_level   = 1'b0;
                end
                else if (s.sub_step == 3'd1)
                    r.sda_level = 1'b0;
                else if (s.sub_step == 3'd2)
                    r.scl_level = 1'b1;
                else
                    r.sda_level = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    state_t     n;
    res_t       o;
    logic       run_phase;
    logic [7:0] lim;
    logic [7:0] shifted;

    always_comb
    begin
        n         = st;
        o         = '0;
        run_phase = 1'b1;
        lim       = (cfg_val.ack_poll_limit != 8'd0) ? cfg_val.ack_poll_limit : 8'd1;
        shifted   = 8'd0;

        // a new command is taken only while idle
        if (n.seq_step == SEG_IDLE &&
            (cmd_item.func == FUNC_WRITE || cmd_item.func == FUNC_READ))
        begin
            n.held_device_addr   = cmd_item.device_addr;
            n.held_register_addr = cmd_item.register_addr;
            n.held_wr_data       = cmd_item.wr_data;
            if (cmd_item.func == FUNC_WRITE)
            begin
                n.is_read    = 1'b0;
                n.bytes_left = 8'd0;
                n         = init_segment(n, SEG_WR_START);
            end
            else
            begin
                n.is_read    = 1'b1;
                n.bytes_left = (cmd_item.read_length != 8'd0) ? cmd_item.read_length : 8'd1;
                n            = init_segment(n, SEG_RD_START);
            end
        end

        if (n.seq_step != SEG_IDLE)
        begin
            o.busy_res = 1'b1;
            // acknowledge poll while scl is high
            if (kind_of(n.seq_step) == K_WA && n.sub_step == 3'd3)
            begin
                if (cmd_item.sda_in)
                begin
                    if (n.poll_count < lim)
                        n.poll_count = n.poll_count + 8'd1;
                    if (n.poll_count >= lim)
                    begin
                        n.scl_level   = 1'b0;
                        o.ack_missing = 1'b1;
                        n             = advance(n);
                    end
                    run_phase = 1'b0;
                end
                else
                begin
                    n.sub_step    = 3'd4;
                    n.phase_count = 8'd0;
                end
            end

            if (run_phase)
            begin
                if (n.phase_count == 8'd0)
                begin
                    n             = enter_phase(n);
                    n.phase_count = (cfg_val.phase_ticks != 8'd0) ? cfg_val.phase_ticks : 8'd1;
                end
                n.phase_count = n.phase_count - 8'd1;
                if (n.phase_count == 8'd0)
                begin
                    case (kind_of(n.seq_step))
                        K_START:
                        begin
                            if (n.sub_step < 3'd2)
                                n.sub_step = n.sub_step + 3'd1;
                            else
                                n = advance(n);
                        end
                        K_WB:
                        begin
                            if (n.sub_step < 3'd2)
                                n.sub_step = n.sub_step + 3'd1;
                            else if (n.sub_step == 3'd2)
                            begin
                                if (n.bit_index == 3'd7)
                                    n.sub_step = 3'd3;
                                else
                                begin
                                    n.bit_index = n.bit_index + 3'd1;
                                    n.sub_step  = 3'd0;
                                end
                            end
                            else
                                n = advance(n);
                        end
                        K_WA:
                        begin
                            if (n.sub_step < 3'd3)
                                n.sub_step = n.sub_step + 3'd1;
                            else
                                n = advance(n);
                        end
                        K_RB:
                        begin
                            if (n.sub_step == 3'd0)
                                n.sub_step = 3'd1;
                            else if (n.sub_step == 3'd1)
                            begin
                                shifted      = {n.shift_byte[6:0], cmd_item.sda_in};
                                n.shift_byte = shifted;
                                if (n.bit_index == 3'd7)
                                begin
                                    o.rd_valid = 1'b1;
                                    o.rd_data  = shifted;
                                    o.rd_last  = (n.bytes_left <= 8'd1);
                                    n.sub_step = 3'd2;
                                end
                                else
                                begin
                                    n.bit_index = n.bit_index + 3'd1;
                                    n.sub_step  = 3'd0;
                                end
                            end
                            else
                                n = advance(n);
                        end
                        K_ACK:
                        begin
                            if (n.sub_step < 3'd3)
                                n.sub_step = n.sub_step + 3'd1;
                            else
                            begin
                                if (n.bytes_left != 8'd0)
                                    n.bytes_left = n.bytes_left - 8'd1;
                                n = advance(n);
                            end
                        end
                        K_STOP:
                        begin
                            if (n.sub_step < 3'd3)
                                n.sub_step = n.sub_step + 3'd1;
                            else
                            begin
                                o.done_res = 1'b1;
                                n          = init_segment(n, SEG_IDLE);
                            end
                        end
                        default: n = init_segment(n, SEG_IDLE);
                    endcase
                end
            end
        end

        o.scl_out   = n.scl_level;
        o.sda_out   = n.sda_level;
        o.sda_drive = n.sda_dir_out;
    end

    assign st_next  = n;
    assign res_item = o;

endmodule

// File: hdl/i2c_register_master.sv
// ----------------------------------------------------------------------------
// i2c_register_master
// Tick-driven I2C master for single register writes and burst reads.
// ----------------------------------------------------------------------------
// Each command item is one bus tick carrying the sampled SDA level and an
// optional write or burst-read command; every tick yields exactly one result
// item with the SCL/SDA levels, SDA direction and read/status flags. One item
// is accepted per clock cycle while the result side takes results; a stall
// there holds the flow. An input register holds the tick, the sequencer step
// logic works on it, and the result register holds the outcome. Each register
// loads when it is empty or being emptied, so the result register stalling on
// the far side only blocks the input once both stages are full. Configuration
// writes (phase length and acknowledge poll limit) take effect for later ticks.
// ----------------------------------------------------------------------------
module i2c_register_master
(
    input  logic        clk,
    input  logic        rst_n,
    i2crm_cmd_if.sink   cmd,
    i2crm_res_if.source res,
    i2crm_cfg_if.sink   cfg
);
    import i2crm_pkg::*;

    cfg_t   cfg_val;
    state_t st_reg;
    state_t st_next;
    cmd_t   in_item;
    cmd_t   s1_item_reg;
    logic   s1_valid_reg;
    res_t   out_next;
    res_t   out_item_reg;
    logic   out_valid_reg;
    logic   adv;

    i2crm_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    i2crm_step u_step
    (
        .st       (st_reg),
        .cfg_val  (cfg_val),
        .cmd_item (s1_item_reg),
        .st_next  (st_next),
        .res_item (out_next)
    );

    assign in_item.func          = cmd.func;
    assign in_item.device_addr   = cmd.device_addr;
    assign in_item.register_addr = cmd.register_addr;
    assign in_item.wr_data       = cmd.wr_data;
    assign in_item.read_length   = cmd.read_length;
    assign in_item.sda_in        = cmd.sda_in;

    // the held tick moves on when the result slot is free or being emptied
    assign adv       = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= STATE_RESET;
        end
        else
        begin
            if (cmd.ready)
                s1_valid_reg <= cmd.valid;
            if (adv)
            begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            s1_item_reg <= in_item;
        if (adv)
            out_item_reg <= out_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_out     = out_item_reg.scl_out;
    assign res.sda_out     = out_item_reg.sda_out;
    assign res.sda_drive   = out_item_reg.sda_drive;
    assign res.rd_data     = out_item_reg.rd_data;
    assign res.rd_valid    = out_item_reg.rd_valid;
    assign res.rd_last     = out_item_reg.rd_last;
    assign res.ack_missing = out_item_reg.ack_missing;
    assign res.busy_res    = out_item_reg.busy_res;
    assign res.done_res    = out_item_reg.done_res;

    // a finished stop leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && out_next.done_res |=> st_reg.seq_step == SEG_IDLE)
        else $error("sequencer not idle after stop");

    // an idle sequencer carries no partial phase
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.seq_step == SEG_IDLE |-> st_reg.sub_step == 3'd0 && st_reg.phase_count == 8'd0)
        else $error("idle sequencer holds phase state");

    // the last-byte flag only comes with a received byte
    a_last_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.rd_last |-> res.rd_valid && res.busy_res)
        else $error("rd_last without a received byte");

    // a result register only fills from an advancing tick
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg ##1 out_valid_reg |-> $past(adv))
        else $error("result appeared without an item");

endmodule
